// ===== src/replacement_selection_run_former_unit_defines.svh =====
// Assertion macros used by the port-level checker of the run former, rsrf_checker.
// No dependencies; include by bare file name.
`ifndef REPLACEMENT_SELECTION_RUN_FORMER_UNIT_DEFINES_SVH
`define REPLACEMENT_SELECTION_RUN_FORMER_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define RSRF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define RSRF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rsrf_pkg.sv =====
// Shared constants, types and operation codes of the replacement-selection run former.
// No dependencies; every other file of the block but the assertion macros header refers to it by scoped names.
`default_nettype none

package rsrf_pkg;

   localparam int SLOTS        = 8;
   localparam int KEY_BITS     = 32;
   localparam int IN_KEY_BITS  = 32;
   localparam int OUT_KEY_BITS = 32;
   localparam int RUN_BITS     = 16;
   localparam int IDX_BITS     = $clog2(SLOTS);
   localparam int CNT_BITS     = $clog2(SLOTS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int OP_BITS      = 2;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [OP_BITS-1:0]  op_type;

   // Operation codes chosen by the front end for each accepted item.
   localparam op_type OP_FILL  = 2'd0;   // store the key, no result
   localparam op_type OP_EMIT  = 2'd1;   // store the key, emit one key
   localparam op_type OP_DRAIN = 2'd2;   // store the key, emit every held key

   typedef struct packed {
      key_type key;
      op_type  op;
   } entry_type;

endpackage

`default_nettype wire

// ===== src/rsrf_req_if.sv =====
// Request channel of the run former: valid/ready handshake with the input key.
// Depends on rsrf_pkg for field widths.
`default_nettype none

interface rsrf_req_if;
   logic                               valid;
   logic                               ready;
   logic [rsrf_pkg::IN_KEY_BITS-1:0]   key_value;
   logic                               final_key;

   modport source (output valid, output key_value, output final_key, input ready);
   modport sink   (input valid, input key_value, input final_key, output ready);
endinterface

`default_nettype wire

// ===== src/rsrf_rsp_if.sv =====
// Response channel of the run former: valid/ready handshake with the emitted key.
// Depends on rsrf_pkg for field widths.
`default_nettype none

interface rsrf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rsrf_pkg::OUT_KEY_BITS-1:0]  out_key;
   logic [rsrf_pkg::RUN_BITS-1:0]      run_number;
   logic                               run_begin;
   logic                               batch_done;
   logic                               item_last;

   modport source (output valid, output out_key, output run_number, output run_begin,
                   output batch_done, output item_last, input ready);
   modport sink   (input valid, input out_key, input run_number, input run_begin,
                   input batch_done, input item_last, output ready);
endinterface

`default_nettype wire

// ===== src/rsrf_front.sv =====
// Front end: accepts request transfers and classifies each key as fill, emit or drain.
// Depends on rsrf_pkg and rsrf_req_if; feeds rsrf_queue.
`default_nettype none

module rsrf_front (
   input  wire logic                clock,
   input  wire logic                reset,
   rsrf_req_if.sink                 req_ch,
   input  wire logic                q_full,
   output logic                     push,
   output rsrf_pkg::entry_type      push_entry
);

   // Keys held by the buffer before the current key is stored.
   logic [rsrf_pkg::IDX_BITS-1:0] fill_ff, fill_in;

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   always_comb begin
      fill_in          = fill_ff;
      push_entry.key   = rsrf_pkg::KEY_BITS'(req_ch.key_value);
      push_entry.op    = rsrf_pkg::OP_FILL;
      if (req_ch.final_key) begin
         push_entry.op = rsrf_pkg::OP_DRAIN;
         fill_in       = '0;
      end else if (fill_ff == rsrf_pkg::IDX_BITS'(rsrf_pkg::SLOTS - 1)) begin
         // Buffer stays full: one key leaves for every key that comes in.
         push_entry.op = rsrf_pkg::OP_EMIT;
      end else begin
         fill_in       = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (push) begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rsrf_queue.sv =====
// Short queue that decouples the classifying front end from the selection back end.
// Depends on rsrf_pkg for the entry type and depth.
`default_nettype none

module rsrf_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  rsrf_pkg::entry_type      push_entry,
   output logic                     full,
   output logic                     head_valid,
   output rsrf_pkg::entry_type      head_entry,
   input  wire logic                pop
);

   rsrf_pkg::entry_type store [rsrf_pkg::QUEUE_DEPTH];

   logic [rsrf_pkg::QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [rsrf_pkg::QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [rsrf_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                           do_push, do_pop;

   assign full       = (count_ff == rsrf_pkg::QCNT_BITS'(rsrf_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store[rptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == rsrf_pkg::QPTR_BITS'(rsrf_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == rsrf_pkg::QPTR_BITS'(rsrf_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rsrf_back.sv =====
// Back end: slot buffer, sequential min-selection scan, freeze and run-close control,
// and the registered response stage. Depends on rsrf_pkg and rsrf_rsp_if.
`default_nettype none

module rsrf_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  rsrf_pkg::entry_type      q_entry,
   output logic                     q_pop,
   rsrf_rsp_if.source               rsp_ch
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   // Slot key store: one write port (insert), one registered read port (scan).
   rsrf_pkg::key_type slot_keys [rsrf_pkg::SLOTS];

   logic [1:0]                     state_ff, state_in;
   logic [rsrf_pkg::SLOTS-1:0]     valid_ff, valid_in;
   logic [rsrf_pkg::SLOTS-1:0]     frozen_ff, frozen_in;
   logic [rsrf_pkg::CNT_BITS-1:0]  fill_ff, fill_in;
   logic                           fresh_ff, fresh_in;
   logic [rsrf_pkg::RUN_BITS-1:0]  run_ff, run_in;
   rsrf_pkg::key_type              last_ff, last_in;
   rsrf_pkg::op_type               op_ff, op_in;

   logic [rsrf_pkg::CNT_BITS-1:0]  scan_cnt_ff, scan_cnt_in;
   logic                           rd_live_ff, rd_live_in;
   rsrf_pkg::key_type              rd_key_ff;
   logic                           rd_ok_ff;
   logic [rsrf_pkg::IDX_BITS-1:0]  rd_idx_ff;
   logic [rsrf_pkg::IDX_BITS-1:0]  scan_idx;

   logic                           best_found_ff, best_found_in;
   logic [rsrf_pkg::IDX_BITS-1:0]  best_idx_ff, best_idx_in;
   rsrf_pkg::key_type              best_key_ff, best_key_in;

   logic                           out_valid_ff, out_valid_in;
   logic [rsrf_pkg::OUT_KEY_BITS-1:0] out_key_ff, out_key_in;
   logic [rsrf_pkg::RUN_BITS-1:0]  out_run_ff, out_run_in;
   logic                           out_begin_ff, out_begin_in;
   logic                           out_done_ff, out_done_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_load;

   logic [rsrf_pkg::IDX_BITS-1:0]  ins_idx;
   logic                           mem_we;
   logic                           out_free;
   logic                           drain_end;

   assign scan_idx  = scan_cnt_ff[rsrf_pkg::IDX_BITS-1:0];
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign drain_end = (op_ff == rsrf_pkg::OP_DRAIN) && (fill_ff == rsrf_pkg::CNT_BITS'(1));

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_key    = out_key_ff;
   assign rsp_ch.run_number = out_run_ff;
   assign rsp_ch.run_begin  = out_begin_ff;
   assign rsp_ch.batch_done = out_done_ff;
   assign rsp_ch.item_last  = out_last_ff;

   // Lowest free slot takes the incoming key.
   always_comb begin
      ins_idx = '0;
      for (int i = rsrf_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            ins_idx = rsrf_pkg::IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      frozen_in     = frozen_ff;
      fill_in       = fill_ff;
      fresh_in      = fresh_ff;
      run_in        = run_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_live_in    = 1'b0;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      out_load      = 1'b0;
      q_pop         = 1'b0;
      mem_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop              = 1'b1;
               mem_we             = 1'b1;
               valid_in[ins_idx]  = 1'b1;
               frozen_in[ins_idx] = 1'b0;
               fill_in            = fill_ff + 1'b1;
               op_in              = q_entry.op;
               if (q_entry.op != rsrf_pkg::OP_FILL) begin
                  state_in      = ST_SCAN;
                  scan_cnt_in   = '0;
                  best_found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // Read of slot n is issued in the cycle before it is compared.
            if (scan_cnt_ff < rsrf_pkg::CNT_BITS'(rsrf_pkg::SLOTS)) begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
               rd_live_in  = 1'b1;
            end else begin
               state_in    = ST_DECIDE;
            end
            if (rd_live_ff && rd_ok_ff && (!best_found_ff || rd_key_ff < best_key_ff)) begin
               best_found_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_key_in   = rd_key_ff;
            end
         end
         ST_DECIDE: begin
            scan_cnt_in   = '0;
            best_found_in = 1'b0;
            if (!best_found_ff) begin
               // Every held key is frozen: close the run and start the next one.
               run_in    = run_ff + 1'b1;
               frozen_in = '0;
               fresh_in  = 1'b1;
               state_in  = ST_SCAN;
            end else if (fresh_ff || best_key_ff >= last_ff) begin
               state_in  = ST_EMIT;
            end else begin
               frozen_in[best_idx_ff] = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load                = 1'b1;
               last_in                 = best_key_ff;
               fresh_in                = 1'b0;
               valid_in[best_idx_ff]   = 1'b0;
               frozen_in[best_idx_ff]  = 1'b0;
               fill_in                 = fill_ff - 1'b1;
               scan_cnt_in             = '0;
               best_found_in           = 1'b0;
               if (drain_end) begin
                  // Batch finished: back to the state after reset.
                  valid_in  = '0;
                  frozen_in = '0;
                  fresh_in  = 1'b1;
                  run_in    = '0;
                  fill_in   = '0;
                  state_in  = ST_IDLE;
               end else if (op_ff == rsrf_pkg::OP_DRAIN) begin
                  state_in  = ST_SCAN;
               end else begin
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_key_in   = out_key_ff;
      out_run_in   = out_run_ff;
      out_begin_in = out_begin_ff;
      out_done_in  = out_done_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_key_in   = rsrf_pkg::OUT_KEY_BITS'(best_key_ff);
         out_run_in   = run_ff;
         out_begin_in = fresh_ff;
         out_done_in  = drain_end;
         out_last_in  = (op_ff == rsrf_pkg::OP_EMIT) || drain_end;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_keys[ins_idx] <= q_entry.key;
      end
      rd_key_ff <= slot_keys[scan_idx];
   end

   always_ff @(posedge clock) begin
      rd_ok_ff    <= valid_ff[scan_idx] && !frozen_ff[scan_idx];
      rd_idx_ff   <= scan_idx;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      last_ff     <= last_in;
      op_ff       <= op_in;
      out_key_ff  <= out_key_in;
      out_run_ff  <= out_run_in;
      out_begin_ff <= out_begin_in;
      out_done_ff <= out_done_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         frozen_ff     <= '0;
         fill_ff       <= '0;
         fresh_ff      <= 1'b1;
         run_ff        <= '0;
         scan_cnt_ff   <= '0;
         rd_live_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         frozen_ff     <= frozen_in;
         fill_ff       <= fill_in;
         fresh_ff      <= fresh_in;
         run_ff        <= run_in;
         scan_cnt_ff   <= scan_cnt_in;
         rd_live_ff    <= rd_live_in;
         best_found_ff <= best_found_in;
         out_valid_ff  <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/replacement_selection_run_former_unit.sv =====
// A key that causes a result passes the front end, the queue, the back end's insert, the
// min scan over the slot store, the decide and emit states and the registered response stage;
// each frozen slot or run close along the way adds another scan. A filling key needs no scan;
// a key that emits holds the back end for the one-slot-per-cycle min scan, while the queue
// takes further keys until it is full. A final key drains every held key, with a new scan
// for each further key. Reset is synchronous and returns the block to an empty buffer,
// run number zero and an empty queue.
`default_nettype none

module replacement_selection_run_former_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   rsrf_req_if.sink     req_ch,
   rsrf_rsp_if.source   rsp_ch
);

   logic                   push;
   rsrf_pkg::entry_type    push_entry;
   logic                   q_full;
   logic                   q_valid;
   rsrf_pkg::entry_type    q_entry;
   logic                   q_pop;

   rsrf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rsrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (q_entry),
      .pop        (q_pop)
   );

   rsrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== src/rsrf_checker.sv =====
// Port-level checks of the run former's response stream, bound to the top level.
// Depends on rsrf_pkg and the assertion macros header.
`default_nettype none
`include "replacement_selection_run_former_unit_defines.svh"

module rsrf_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [rsrf_pkg::OUT_KEY_BITS-1:0]  out_key,
   input wire logic [rsrf_pkg::RUN_BITS-1:0]      run_number,
   input wire logic                               run_begin,
   input wire logic                               batch_done,
   input wire logic                               item_last
);

   logic                               have_prev_ff, have_prev_in;
   logic [rsrf_pkg::OUT_KEY_BITS-1:0]  prev_key_ff, prev_key_in;
   logic                               rsp_xfer;

   assign rsp_xfer     = rsp_valid && rsp_ready;
   assign have_prev_in = have_prev_ff || rsp_xfer;
   assign prev_key_in  = rsp_xfer ? out_key : prev_key_ff;

   always_ff @(posedge clock) begin
      prev_key_ff <= prev_key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
   end

   `RSRF_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_key) && $stable(run_number),
      "stalled response changed")

   `RSRF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid,
      "response valid right after reset")

   `RSRF_ASSERT(a_done_is_last, clock, reset, rsp_valid && batch_done |-> item_last,
      "batch end not marked as the last result of its item")

   `RSRF_ASSERT(a_run_ascends, clock, reset,
      rsp_xfer && have_prev_ff && !run_begin |-> out_key >= prev_key_ff,
      "key below its predecessor within one run")

endmodule

bind replacement_selection_run_former_unit rsrf_checker u_rsrf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .out_key    (rsp_ch.out_key),
   .run_number (rsp_ch.run_number),
   .run_begin  (rsp_ch.run_begin),
   .batch_done (rsp_ch.batch_done),
   .item_last  (rsp_ch.item_last)
);

`default_nettype wire

// ===== dv/rsrf_run_checker.sv =====
// Result checker for the replacement-selection run former: predicts emitted keys and compares.
// Depends on rsrf_pkg and the rsrf_req_if / rsrf_rsp_if channel interfaces.
`timescale 1ns / 1ps

module rsrf_run_checker (
   input  logic  clock,
   input  logic  reset,
   rsrf_req_if   req_mon,
   rsrf_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending_count
);

   localparam int SLOTS = rsrf_pkg::SLOTS;

   typedef struct packed {
      logic [rsrf_pkg::OUT_KEY_BITS-1:0] out_key;
      logic [rsrf_pkg::RUN_BITS-1:0]     run_number;
      logic                              run_begin;
      logic                              batch_done;
      logic                              item_last;
   } run_key_type;

   // Mirror of the selection buffer.
   rsrf_pkg::key_type             slot_key [SLOTS];
   logic                          slot_live [SLOTS];
   logic                          slot_frozen [SLOTS];
   rsrf_pkg::key_type             prev_key;
   logic                          fresh_run;
   logic [rsrf_pkg::RUN_BITS-1:0] run_idx;
   int                            held;
   run_key_type                   due_keys [$];

   task automatic clear_batch();
      for (int i = 0; i < SLOTS; i++) begin
         slot_key[i]    = '0;
         slot_live[i]   = 1'b0;
         slot_frozen[i] = 1'b0;
      end
      prev_key  = '0;
      fresh_run = 1'b1;
      run_idx   = '0;
      held      = 0;
   endtask

   // Smallest live, unfrozen slot; ties go to the lowest index. -1 if none.
   function automatic int pick_smallest();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && !slot_frozen[i]) begin
            if (best < 0 || slot_key[i] < slot_key[best]) best = i;
         end
      end
      return best;
   endfunction

   task automatic emit_next(input logic draining);
      int          s;
      run_key_type r;
      s = pick_smallest();
      // Freeze keys that would break the ascending order; close the run when all are frozen.
      while (s < 0 || (!fresh_run && slot_key[s] < prev_key)) begin
         if (s < 0) begin
            run_idx++;
            for (int i = 0; i < SLOTS; i++) slot_frozen[i] = 1'b0;
            fresh_run = 1'b1;
         end else begin
            slot_frozen[s] = 1'b1;
         end
         s = pick_smallest();
      end
      r.out_key    = slot_key[s];
      r.run_number = run_idx;
      r.run_begin  = fresh_run;
      r.batch_done = draining && (held == 1);
      r.item_last  = !draining;
      due_keys.insert(due_keys.size(), r);
      prev_key       = slot_key[s];
      fresh_run      = 1'b0;
      slot_live[s]   = 1'b0;
      slot_frozen[s] = 1'b0;
      held--;
   endtask

   task automatic absorb_key(input rsrf_pkg::key_type k, input logic is_final);
      logic placed;
      placed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_live[i] && !placed) begin
            slot_key[i]    = k;
            slot_live[i]   = 1'b1;
            slot_frozen[i] = 1'b0;
            held++;
            placed = 1'b1;
         end
      end
      if (!is_final) begin
         if (held >= SLOTS) emit_next(1'b0);
      end else begin
         while (held > 0) emit_next(1'b1);
         due_keys[due_keys.size() - 1].item_last = 1'b1;
         clear_batch();
      end
   endtask

   always @(posedge clock) begin
      run_key_type seen;
      run_key_type want;
      if (reset) begin
         clear_batch();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.out_key, rsp_mon.run_number, rsp_mon.run_begin,
                    rsp_mon.batch_done, rsp_mon.item_last};
            if (due_keys.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result key=%h run=%0d begin=%b done=%b last=%b",
                           $realtime, seen.out_key, seen.run_number, seen.run_begin,
                           seen.batch_done, seen.item_last);
            end else begin
               want = due_keys.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch exp key=%h run=%0d begin=%b done=%b last=%b / %s",
                              $realtime, want.out_key, want.run_number, want.run_begin,
                              want.batch_done, want.item_last,
                              $sformatf("got key=%h run=%0d begin=%b done=%b last=%b",
                                        seen.out_key, seen.run_number, seen.run_begin,
                                        seen.batch_done, seen.item_last));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) absorb_key(req_mon.key_value, req_mon.final_key);
      end
      pending_count = due_keys.size();
   end

endmodule

// ===== dv/tb_replacement_selection_run_former_unit.sv =====
// Top of the run former testbench: clock, reset, key stimulus, receiver stalls and verdict.
// Depends on rsrf_pkg, the channel interfaces, rsrf_run_checker and the unit itself.
`timescale 1ns / 1ps

module tb_replacement_selection_run_former_unit;

   localparam int SLOTS        = rsrf_pkg::SLOTS;
   localparam int RANDOM_ITEMS = 260;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 100;
   localparam int CYCLE_LIMIT  = 500000;

   logic clock = 1'b0;
   logic reset;
   logic rsp_hold;
   logic hold_start = 1'b0;
   int   send_idle_pct = 19;
   int   rsp_idle_pct = 78;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;

   rsrf_req_if req_ch ();
   rsrf_rsp_if rsp_ch ();

   replacement_selection_run_former_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rsrf_run_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Long receiver hold-off so the unit backs up and stalls its input.
   initial begin
      rsp_hold = 1'b0;
      wait (hold_start);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_key(input rsrf_pkg::key_type k, input logic is_final);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.key_value <= k;
      req_ch.final_key <= is_final;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int                random_sent;
      int                batch_len;
      int                key_mode;
      int                phase;
      rsrf_pkg::key_type seq;
      rsrf_pkg::key_type k;
      req_ch.valid     = 1'b0;
      req_ch.key_value = '0;
      req_ch.final_key = 1'b0;
      rsp_ch.ready     = 1'b0;
      reset            = 1'b1;
      random_sent      = 0;
      phase            = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A final key into an empty buffer drains only itself.
      send_key('0, 1'b1);
      // Short batch with two equal keys: the lower slot leaves first.
      send_key('1, 1'b0);
      send_key(32'd5, 1'b0);
      send_key(32'd5, 1'b1);
      // Descending fill, then keys below the last output freeze slots; the drain
      // runs into an all-frozen buffer and closes the run.
      for (int j = 0; j < SLOTS; j++) send_key(32'd100 - 10 * j, 1'b0);
      send_key(32'd20, 1'b0);
      send_key(32'd10, 1'b0);
      send_key(32'd5, 1'b0);
      send_key(32'd1, 1'b0);
      send_key('1, 1'b1);
      // Full buffer of identical maximum keys.
      for (int j = 0; j < SLOTS; j++) send_key('1, j == SLOTS - 1);

      while (random_sent < RANDOM_ITEMS) begin
         batch_len = ($urandom_range(3) == 0) ? $urandom_range(1, SLOTS)
                                              : $urandom_range(SLOTS + 1, 40);
         key_mode  = $urandom_range(4);
         if (phase == 1 && random_sent >= RANDOM_ITEMS / 3) begin
            phase         = 2;
            send_idle_pct = 78;
            rsp_idle_pct <= 19;
         end else if (phase == 2 && random_sent >= 2 * RANDOM_ITEMS / 3) begin
            phase         = 3;
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
            hold_start    = 1'b1;
            batch_len     = 30;
            key_mode      = 0;
         end
         seq = $urandom();
         for (int j = 0; j < batch_len; j++) begin
            unique case (key_mode)
               0: k = $urandom();
               1: k = $urandom_range(15);
               2: begin
                  seq = seq + $urandom_range(8);
                  k   = seq;
               end
               3: begin
                  // Falling keys keep freezing slots and closing runs.
                  seq = seq - $urandom_range(8);
                  k   = seq;
               end
               default: k = $urandom_range(1) ? '1 : rsrf_pkg::key_type'($urandom_range(3));
            endcase
            send_key(k, j == batch_len - 1);
            random_sent++;
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
